@@ hw/rtl/dht_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_pkg
// Shared constants, codes and widths for the double-hashing table core.
// ----------------------------------------------------------------------------
package dht_pkg;

  localparam int MAX_SLOTS = 1024;
  localparam int IDX_W     = $clog2(MAX_SLOTS);      // memory address bits
  localparam int LEN_W     = $clog2(MAX_SLOTS) + 1;  // holds MAX_SLOTS itself
  localparam int KEY_W     = 10;                     // key and slot contents
  localparam int OUT_IDX_W = 10;                     // reported slot index
  localparam int STAT_W    = 3;
  localparam int ACT_W     = 2;
  localparam int DCNT_W    = $clog2(KEY_W + 1);

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd4;

endpackage

@@ hw/rtl/double_hash_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_hash_table_core
// Open-addressed hash table with double hashing over a 1024-slot store.
// ----------------------------------------------------------------------------
//  channel   | signals                          | handshake
//  ----------+----------------------------------+---------------------------
//  request   | start, action, key               | taken when start && !busy
//  result    | done, status, slot_index         | one-cycle strobe, no stall
//  config    | cfg_valid, cfg_ready, cfg_data   | written when valid && ready
//
//  Insert/search: capture, key mod length, step mod (length - 1), GCD/step
//  search (at most ten candidates), one read, then one probe per cycle
//  until a result. The probe loop of the single store read port dominates.
//  Clear zeroes all 1024 slots in turn; after reset the same clearing pass
//  runs with busy high. Key zero or an unused action is answered from idle
//  without a table walk.
// ----------------------------------------------------------------------------
module double_hash_table_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [dht_pkg::ACT_W-1:0]    action,
  input  logic [dht_pkg::KEY_W-1:0]    key,
  output logic                         done,
  output logic [dht_pkg::STAT_W-1:0]   status,
  output logic [dht_pkg::OUT_IDX_W-1:0] slot_index,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [dht_pkg::LEN_W-1:0]    cfg_data
);
  import dht_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLEAR = 7'b0000010,
    S_MOD1  = 7'b0000100,
    S_MOD2  = 7'b0001000,
    S_GCD   = 7'b0010000,
    S_READ  = 7'b0100000,
    S_CHECK = 7'b1000000
  } state_t;

  state_t            state;
  logic [LEN_W-1:0]  table_length;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  len_q;
  logic [ACT_W-1:0]  act;
  logic [KEY_W-1:0]  key_q;
  logic [IDX_W-1:0]  clr_addr;
  logic              clr_report;
  logic [LEN_W-1:0]  pos;
  logic [LEN_W-1:0]  pos_next;
  logic [LEN_W:0]    pos_sum;
  logic [LEN_W-1:0]  step;
  logic [LEN_W-1:0]  step_next;
  logic [LEN_W-1:0]  ga;
  logic [LEN_W-1:0]  gb;
  logic [LEN_W-1:0]  cnt;
  logic [LEN_W-1:0]  cnt_inc;

  logic [KEY_W-1:0]  mem [MAX_SLOTS];
  logic [KEY_W-1:0]  mem_rdata;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [KEY_W-1:0]  wr_data;
  logic              mem_we;

  logic              div_go;
  logic              div_done;
  logic [KEY_W-1:0]  div_dividend;
  logic [LEN_W-1:0]  div_divisor;
  logic [LEN_W-1:0]  div_rem;
  logic              keyed_req;
  logic              is_insert;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign is_insert = (act == ACT_INSERT);

  always_comb begin
    if (table_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (table_length > LEN_W'(MAX_SLOTS)) begin
      len_eff = LEN_W'(MAX_SLOTS);
    end else begin
      len_eff = table_length;
    end
  end

  assign keyed_req = ((action == ACT_INSERT) || (action == ACT_SEARCH)) && (key != '0);

  // shared remainder unit: key mod length, then key mod (length - 1)
  assign div_go = ((state == S_IDLE) && start && keyed_req) ||
                  ((state == S_MOD1) && div_done && (len_q != LEN_W'(1)));
  assign div_dividend = (state == S_IDLE) ? key : key_q;
  assign div_divisor  = (state == S_IDLE) ? len_eff : (len_q - LEN_W'(1));

  dht_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  // next probe position, wrapped into [0, len)
  assign pos_sum  = {1'b0, pos} + {1'b0, step};
  assign pos_next = (pos_sum >= {1'b0, len_q}) ? LEN_W'(pos_sum - {1'b0, len_q})
                                                : pos_sum[LEN_W-1:0];
  assign cnt_inc  = cnt + LEN_W'(1);

  // step candidate raise, wrapping to 1 at the length
  assign step_next = ((step + LEN_W'(1)) >= len_q) ? LEN_W'(1) : (step + LEN_W'(1));

  // read ahead: while checking one slot the next is already being fetched
  assign rd_addr = (state == S_CHECK) ? pos_next[IDX_W-1:0] : pos[IDX_W-1:0];
  assign mem_we  = (state == S_CLEAR) ||
                   ((state == S_CHECK) && is_insert && (mem_rdata == '0));
  assign wr_addr = (state == S_CLEAR) ? clr_addr : pos[IDX_W-1:0];
  assign wr_data = (state == S_CLEAR) ? '0 : key_q;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    mem_rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      clr_report   <= 1'b0;
      done         <= 1'b0;
      table_length <= LEN_W'(MAX_SLOTS);
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        table_length <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            act   <= action;
            key_q <= key;
            len_q <= len_eff;
            if (action == ACT_CLEAR) begin
              state      <= S_CLEAR;
              clr_addr   <= '0;
              clr_report <= 1'b1;
            end else if (keyed_req) begin
              state <= S_MOD1;
            end else begin
              done       <= 1'b1;
              status     <= (action == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
              slot_index <= '0;
            end
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + IDX_W'(1);
          if (clr_addr == IDX_W'(MAX_SLOTS - 1)) begin
            state <= S_IDLE;
            if (clr_report) begin
              done       <= 1'b1;
              status     <= ST_CLEARED;
              slot_index <= '0;
            end
          end
        end
        S_MOD1: begin
          if (div_done) begin
            pos <= div_rem;
            if (len_q == LEN_W'(1)) begin
              step  <= LEN_W'(1);
              cnt   <= '0;
              state <= S_READ;
            end else begin
              state <= S_MOD2;
            end
          end
        end
        S_MOD2: begin
          if (div_done) begin
            step  <= div_rem + LEN_W'(1);
            ga    <= div_rem + LEN_W'(1);
            gb    <= len_q;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          // binary GCD, only asking whether the result is one
          if ((ga == gb) || (!ga[0] && !gb[0])) begin
            if (ga == LEN_W'(1) && gb == LEN_W'(1)) begin
              cnt   <= '0;
              state <= S_READ;
            end else begin
              step <= step_next;
              ga   <= step_next;
              gb   <= len_q;
            end
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga > gb) begin
            ga <= (ga - gb) >> 1;
          end else begin
            gb <= (gb - ga) >> 1;
          end
        end
        S_READ: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (is_insert && (mem_rdata == '0)) begin
            done       <= 1'b1;
            status     <= ST_INSERTED;
            slot_index <= OUT_IDX_W'(pos);
            state      <= S_IDLE;
          end else if (!is_insert && (mem_rdata == key_q)) begin
            done       <= 1'b1;
            status     <= ST_FOUND;
            slot_index <= OUT_IDX_W'(pos);
            state      <= S_IDLE;
          end else if ((!is_insert && (mem_rdata == '0)) || (cnt_inc == len_q)) begin
            done       <= 1'b1;
            status     <= is_insert ? ST_FULL : ST_NOT_FOUND;
            slot_index <= '0;
            state      <= S_IDLE;
          end else begin
            cnt <= cnt_inc;
            pos <= pos_next;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CHECK) |-> (pos < len_q) && (cnt < len_q))
    else $error("probe outside table");

  a_step_valid: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> (step != '0) && ((step < len_q) || (len_q == LEN_W'(1))))
    else $error("bad probe step");

  a_empty_index: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_FULL || status == ST_NOT_FOUND || status == ST_CLEARED))
      |-> (slot_index == '0))
    else $error("index reported without a slot");

  a_write_only_insert: assert property (@(posedge clk) disable iff (rst)
    (mem_we && (state == S_CHECK)) |=> done && (status == ST_INSERTED))
    else $error("store write without insert result");
`endif

endmodule

@@ hw/rtl/dht_mod_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dht_mod_unit
// Bit-serial restoring remainder: dividend mod divisor, one key bit a cycle.
// ----------------------------------------------------------------------------
module dht_mod_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       go,
  input  logic [dht_pkg::KEY_W-1:0]  dividend,
  input  logic [dht_pkg::LEN_W-1:0]  divisor,
  output logic                       done,
  output logic [dht_pkg::LEN_W-1:0]  remainder
);
  import dht_pkg::*;

  logic              active;
  logic [DCNT_W-1:0] cnt;
  logic [KEY_W-1:0]  shreg;
  logic [LEN_W-1:0]  div_q;
  logic [LEN_W:0]    trial;
  logic [LEN_W:0]    trial_sub;

  assign trial     = {remainder, shreg[KEY_W-1]};
  assign trial_sub = trial - {1'b0, div_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        active    <= 1'b1;
        cnt       <= DCNT_W'(KEY_W);
        shreg     <= dividend;
        div_q     <= divisor;
        remainder <= '0;
      end else if (active) begin
        // remainder stays below the divisor, so the top bit drops out
        if (trial >= {1'b0, div_q}) begin
          remainder <= trial_sub[LEN_W-1:0];
        end else begin
          remainder <= trial[LEN_W-1:0];
        end
        shreg <= {shreg[KEY_W-2:0], 1'b0};
        cnt   <= cnt - DCNT_W'(1);
        if (cnt == DCNT_W'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_rem_below_div: assert property (@(posedge clk) disable iff (rst)
    done |-> (remainder < div_q))
    else $error("remainder not below divisor");

  a_done_ends_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(active) && !active)
    else $error("done without a finished run");

  a_cnt_live: assert property (@(posedge clk) disable iff (rst)
    active |-> (cnt != '0))
    else $error("active with zero count");
`endif

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for double_hash_table_core: drives insert, search,
// clear and odd requests under a range of table lengths, predicts every
// reply with its own double-hashing table and checks each done strobe.
// ----------------------------------------------------------------------------
module tb;
  import dht_pkg::*;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int unsigned DRAIN_CYCLES = 1100;

  typedef struct packed {
    logic [STAT_W-1:0]    code;
    logic [OUT_IDX_W-1:0] slot;
  } reply_t;

  // Shadow of the slot store plus the queue of replies still owed by the core.
  class slot_table_tracker;
    logic [KEY_W-1:0] slots [MAX_SLOTS];
    logic [LEN_W-1:0] length_reg;
    reply_t           expected_replies [$];
    int               errors;

    function new();
      foreach (slots[i]) slots[i] = '0;
      length_reg = LEN_W'(MAX_SLOTS);
      errors = 0;
    endfunction

    function void set_length(logic [LEN_W-1:0] v);
      length_reg = v;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k);
      int unsigned len, s, pos, a, b, r, i;
      reply_t rep;
      rep.code = ST_NOT_FOUND;
      rep.slot = '0;
      if (act == ACT_CLEAR) begin
        foreach (slots[j]) slots[j] = '0;
        rep.code = ST_CLEARED;
      end else if (act == ACT_INSERT || act == ACT_SEARCH) begin
        rep.code = (act == ACT_INSERT) ? ST_FULL : ST_NOT_FOUND;
        if (k != '0) begin
          if (length_reg == '0) len = 1;
          else if (length_reg > LEN_W'(MAX_SLOTS)) len = MAX_SLOTS;
          else len = 32'(length_reg);
          // step: 1 + k mod (len-1), bumped (wrapping to 1) until coprime with len
          s = 1;
          if (len > 1) begin
            s = 1 + 32'(k) % (len - 1);
            forever begin
              a = s;
              b = len;
              while (b != 0) begin
                r = a % b;
                a = b;
                b = r;
              end
              if (a == 1) break;
              s++;
              if (s >= len) s = 1;
            end
          end
          pos = 32'(k) % len;
          for (i = 0; i < len; i++) begin
            if (act == ACT_INSERT) begin
              if (slots[pos] == '0) begin
                slots[pos] = k;
                rep.code = ST_INSERTED;
                rep.slot = OUT_IDX_W'(pos);
                break;
              end
            end else begin
              if (slots[pos] == k) begin
                rep.code = ST_FOUND;
                rep.slot = OUT_IDX_W'(pos);
                break;
              end
              if (slots[pos] == '0) break;
            end
            pos += s;
            if (pos >= len) pos -= len;
          end
        end
      end
      expected_replies.push_back(rep);
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [STAT_W-1:0] got_code, logic [OUT_IDX_W-1:0] got_slot);
      reply_t want;
      if (expected_replies.size() == 0) begin
        report($sformatf("reply status=%0d slot=%0d with no request pending",
                         got_code, got_slot));
        return;
      end
      want = expected_replies.pop_front();
      if (got_code !== want.code)
        report($sformatf("status %0d, expected %0d", got_code, want.code));
      if (got_slot !== want.slot)
        report($sformatf("slot_index %0d, expected %0d", got_slot, want.slot));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [ACT_W-1:0]     action = '0;
  logic [KEY_W-1:0]     key = '0;
  logic                 done;
  logic [STAT_W-1:0]    status;
  logic [OUT_IDX_W-1:0] slot_index;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [LEN_W-1:0]     cfg_data = '0;

  slot_table_tracker sb;
  bit                steady = 1'b0;
  int unsigned       cycle_count = 0;
  logic [KEY_W-1:0]  stored_keys [$];

  double_hash_table_core u_top (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .key        (key),
    .done       (done),
    .status     (status),
    .slot_index (slot_index),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("double_hash_table_core verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(status, slot_index);
  end

  // Present one request, with an occasional idle gap, and hold it until taken.
  task automatic issue_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] k);
    int unsigned gap;
    gap = (!steady && $urandom_range(99, 0) < 9) ? $urandom_range(6, 1) : 0;
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    action <= act;
    key    <= k;
    do @(posedge clk); while (busy);
    sb.note_request(act, k);
  endtask

  // Only written with the core idle: start dropped and every reply in.
  task automatic write_table_length(input logic [LEN_W-1:0] v);
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_length(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned      len_eff, r, h, m_max;
    logic [KEY_W-1:0] k;
    logic [ACT_W-1:0] a;
    logic [LEN_W-1:0] len_cfg;
    logic [LEN_W-1:0] len_plan [16];

    sb = new();
    len_plan = '{11'd3, 11'd1, 11'd2, 11'd7, 11'd8, 11'd16, 11'd13, 11'd1024,
                 11'd31, 11'd0, 11'd64, 11'd5, 11'd2047, 11'd97, 11'd1536, 11'd12};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: default length, duplicates, key zero, unused action, clear
    issue_request(ACT_SEARCH, 10'd5);
    issue_request(ACT_INSERT, 10'd1);
    issue_request(ACT_INSERT, 10'd1023);
    issue_request(ACT_INSERT, 10'd1);
    issue_request(ACT_SEARCH, 10'd1);
    issue_request(ACT_SEARCH, 10'd1023);
    issue_request(ACT_INSERT, 10'd0);
    issue_request(ACT_SEARCH, 10'd0);
    issue_request(ACT_UNUSED, 10'd77);
    issue_request(ACT_SEARCH, 10'd1022);
    issue_request(ACT_CLEAR, 10'd0);
    issue_request(ACT_SEARCH, 10'd1);
    // zero length behaves as one slot
    write_table_length(11'd0);
    issue_request(ACT_INSERT, 10'd5);
    issue_request(ACT_INSERT, 10'd6);
    issue_request(ACT_SEARCH, 10'd5);
    issue_request(ACT_SEARCH, 10'd7);
    // oversized length saturates; slot 0 still holds the old key
    write_table_length(11'd2047);
    issue_request(ACT_SEARCH, 10'd5);
    issue_request(ACT_INSERT, 10'd1023);
    write_table_length(11'd2);
    issue_request(ACT_INSERT, 10'd4);
    issue_request(ACT_SEARCH, 10'd5);
    issue_request(ACT_SEARCH, 10'd4);
    issue_request(ACT_CLEAR, 10'd1023);

    for (int p = 0; p < 20; p++) begin
      len_cfg = (p >= 16) ? LEN_W'($urandom_range(40, 1)) : len_plan[p];
      write_table_length(len_cfg);
      steady = (p >= 8 && p < 12);
      if (len_cfg == '0) len_eff = 1;
      else if (len_cfg > LEN_W'(MAX_SLOTS)) len_eff = MAX_SLOTS;
      else len_eff = 32'(len_cfg);
      repeat (26) begin
        r = $urandom_range(99, 0);
        k = KEY_W'($urandom_range(1023, 1));
        if (r < 3) begin
          a = ACT_CLEAR;
          k = KEY_W'($urandom_range(1023, 0));
          stored_keys.delete();
        end else if (r < 6) begin
          a = $urandom_range(1, 0) ? ACT_SEARCH : ACT_INSERT;
          k = '0;
        end else if (r < 9) begin
          a = ACT_UNUSED;
          k = KEY_W'($urandom_range(1023, 0));
        end else if (r < 50) begin
          a = ACT_INSERT;
          if ($urandom_range(1, 0)) begin
            // key sharing its home slot with others at this length
            h = $urandom_range(len_eff - 1, 0);
            m_max = (1023 - h) / len_eff;
            k = KEY_W'(h + len_eff * $urandom_range(m_max, 0));
            if (k == '0) k = (len_eff <= 1023) ? KEY_W'(len_eff) : KEY_W'(1);
          end
          stored_keys.push_back(k);
        end else begin
          a = ACT_SEARCH;
          if (stored_keys.size() > 0 && $urandom_range(9, 0) < 7)
            k = stored_keys[$urandom_range(stored_keys.size() - 1, 0)];
        end
        issue_request(a, k);
      end
    end

    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("double_hash_table_core verification clean");
    else
      $display("double_hash_table_core verification failed");
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/dht_pkg.sv
hw/rtl/dht_mod_unit.sv
hw/rtl/double_hash_table_core.sv
sim/tb.sv
